// File: hdl/uer_pkg.sv
// Package for the ultrasonic echo ranger: phase codes, register indexes,
// result layout and the constants of the distance scaling.
// No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

  // Measurement phases; codes above MEASURE behave as idle
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_OLD  = 3'd3,
    PH_WAIT_RISE = 3'd4,
    PH_MEASURE   = 3'd5
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_TRIG_LOW  = 2'd1,
    CFG_TRIG_HIGH = 2'd2
  } cfg_idx_t;

  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned TRIG_W    = 8;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned DIST_W    = 15;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 20'd12000;
  localparam logic [TRIG_W-1:0]    TRIG_LOW_RST  = 8'd2;
  localparam logic [TRIG_W-1:0]    TRIG_HIGH_RST = 8'd10;

  // floor(w / 58) as (w * ceil(2^27 / 58)) >> 27, exact for w below 2^21.
  // Widths at or above 32768 * 58 saturate the distance.
  localparam int unsigned     DIST_SHIFT = 27;
  localparam int unsigned     DIV_IN_W   = 21;
  localparam int unsigned     RECIP_W    = 22;
  localparam int unsigned     PROD_W     = DIV_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIST_RECIP = 22'd2314099;
  localparam logic [31:0]     DIST_SAT_W = 32'd1900544;
  localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;

  // One result item; drive enable sits in bit 0
  typedef struct packed {
    logic              timed_out;
    logic [DIST_W-1:0] distance_cm;
    logic              done_res;
    logic              busy_res;
    logic              pin_level_out;
    logic              pin_drive_enable;
  } res_t;

  localparam int unsigned RES_W    = $bits(res_t);
  localparam int unsigned OUT_TD_W = 24;

endpackage

// File: hdl/ultrasonic_echo_ranger_top.sv
// Top level of the ultrasonic echo ranger: trigger sequencer, echo width
// counter, distance scaling and result register. Depends on uer_pkg.
`timescale 1ns / 1ps
// Output: a result is loaded into the output register when its tick
//   request is accepted.
// Throughput: one tick request per cycle; the next tick is taken while the
//   previous result waits, as long as the output register is free or drains.
// Reset (synchronous, rst_n low): phase idle, counters cleared, registers
//   back to timeout 12000, trigger low 2, trigger high 10; output empty.

module ultrasonic_echo_ranger_top
  import uer_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  // tick requests
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [0] start_req, [1] echo_level
  // results
  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] pin_drive_enable, [1] pin_level_out, [2] busy_res, [3] done_res,
  // [18:4] distance_cm, [19] timed_out
  output logic [OUT_TD_W-1:0] out_tdata,
  // configuration
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  // configuration registers
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [TRIG_W-1:0]    trig_low_r;
  logic [TRIG_W-1:0]    trig_high_r;

  // measurement state
  phase_t               phase_r, phase_nxt;
  logic [TRIG_W-1:0]    tc_r, tc_nxt;
  logic [COUNT_WIDTH-1:0] el_r, el_nxt;
  logic [COUNT_WIDTH-1:0] wc_r, wc_nxt;

  // result register
  logic                 out_valid_r;
  res_t                 res_r, res_nxt;

  logic                 in_fire;
  logic                 start_req, echo_level;

  logic [TRIG_W-1:0]    tc_inc;
  logic                 trig_low_end, trig_high_end;
  logic [COUNT_WIDTH-1:0] el_inc, wc_inc;
  logic [31:0]          tmo32, limit32;
  logic                 tmo_hit;

  logic [31:0]          w32;
  logic                 dist_sat;
  logic [PROD_W-1:0]    prod;
  logic [DIST_W-1:0]    dist_q;

  assign start_req  = in_tdata[0];
  assign echo_level = in_tdata[1];

  // Take a tick whenever the result register is empty or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Trigger counter wraps at 8 bits; a wrap to zero ends the pulse too;
  // a programmed length of zero acts as one tick
  assign tc_inc        = tc_r + 1'b1;
  assign trig_low_end  = (tc_inc >= trig_low_r) || (tc_inc == '0);
  assign trig_high_end = (tc_inc >= trig_high_r) || (tc_inc == '0);

  // Saturating counters
  assign el_inc = (&el_r) ? el_r : el_r + 1'b1;
  assign wc_inc = (&wc_r) ? wc_r : wc_r + 1'b1;

  // Timeout limit is clipped to what the elapsed counter can hold
  assign tmo32   = 32'(timeout_r);
  assign limit32 = (tmo32 < CMAX) ? tmo32 : CMAX;
  assign tmo_hit = 32'(el_inc) >= limit32;

  // Distance: reciprocal multiply, exact below the saturation width
  assign w32      = 32'(wc_r);
  assign dist_sat = w32 >= DIST_SAT_W;
  assign prod     = PROD_W'(w32[DIV_IN_W-1:0]) * PROD_W'(DIST_RECIP);
  assign dist_q   = dist_sat ? DIST_MAX : prod[DIST_SHIFT +: DIST_W];

  // Next state: a level that ends the current wait wins over the timeout
  always_comb begin
    phase_nxt = phase_r;
    tc_nxt    = tc_r;
    el_nxt    = el_r;
    wc_nxt    = wc_r;
    unique case (phase_r)
      PH_TRIG_LOW: begin
        tc_nxt = tc_inc;
        if (trig_low_end) begin
          phase_nxt = PH_TRIG_HIGH;
          tc_nxt    = '0;
        end
      end
      PH_TRIG_HIGH: begin
        tc_nxt = tc_inc;
        if (trig_high_end) begin
          phase_nxt = PH_WAIT_OLD;
          tc_nxt    = '0;
          el_nxt    = '0;
        end
      end
      PH_WAIT_OLD: begin
        el_nxt = el_inc;
        if (!echo_level) begin
          phase_nxt = PH_WAIT_RISE;
        end else if (tmo_hit) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_WAIT_RISE: begin
        el_nxt = el_inc;
        if (echo_level) begin
          wc_nxt    = COUNT_WIDTH'(1);
          phase_nxt = PH_MEASURE;
        end else if (tmo_hit) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_MEASURE: begin
        el_nxt = el_inc;
        if (!echo_level) begin
          phase_nxt = PH_IDLE;
        end else begin
          wc_nxt = wc_inc;
          if (tmo_hit) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        // idle and unused codes: heed a start request
        phase_nxt = PH_IDLE;
        if (start_req) begin
          phase_nxt = PH_TRIG_LOW;
          tc_nxt    = '0;
          el_nxt    = '0;
          wc_nxt    = '0;
        end
      end
    endcase
  end

  // Result of this tick, from the phase at its start
  always_comb begin
    res_nxt          = '0;
    res_nxt.busy_res = 1'b1;
    unique case (phase_r)
      PH_TRIG_LOW: begin
        res_nxt.pin_drive_enable = 1'b1;
      end
      PH_TRIG_HIGH: begin
        res_nxt.pin_drive_enable = 1'b1;
        res_nxt.pin_level_out    = 1'b1;
      end
      PH_WAIT_OLD: begin
        if (echo_level && tmo_hit) begin
          res_nxt.done_res  = 1'b1;
          res_nxt.timed_out = 1'b1;
        end
      end
      PH_WAIT_RISE: begin
        if (!echo_level && tmo_hit) begin
          res_nxt.done_res  = 1'b1;
          res_nxt.timed_out = 1'b1;
        end
      end
      PH_MEASURE: begin
        if (!echo_level) begin
          res_nxt.done_res    = 1'b1;
          res_nxt.distance_cm = dist_q;
        end else if (tmo_hit) begin
          res_nxt.done_res  = 1'b1;
          res_nxt.timed_out = 1'b1;
        end
      end
      default: begin
        res_nxt.busy_res = 1'b0;
      end
    endcase
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      trig_low_r  <= TRIG_LOW_RST;
      trig_high_r <= TRIG_HIGH_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_TRIG_LOW:  trig_low_r  <= cfg_wdata[TRIG_W-1:0];
        CFG_TRIG_HIGH: trig_high_r <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the state only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tc_r    <= '0;
      el_r    <= '0;
      wc_r    <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      tc_r    <= tc_nxt;
      el_r    <= el_nxt;
      wc_r    <= wc_nxt;
    end
  end

  // Output register: load on accept, clear valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'(res_r);

  // A finished measurement leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_nxt.done_res |=> phase_r == PH_IDLE)
    else $error("phase not idle after done");

  // Timeout is only flagged with done and a zero distance
  a_tmo_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.timed_out |-> res_r.done_res && res_r.distance_cm == '0)
    else $error("timeout without done or with distance");

  // The pin is only driven during a measurement
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.pin_drive_enable |-> res_r.busy_res && !res_r.done_res)
    else $error("pin driven outside trigger");

endmodule
